// File: rtl/adag_pkg.sv
`timescale 1ns / 1ps
package adag_pkg;

	localparam int DEF_MAX_ARRAYS = 16;
	localparam int DEF_MAX_DIMS   = 10;

	localparam int ID_FIELD_W  = 4;
	localparam int CNT_FIELD_W = 4;
	localparam int DIM_FIELD_W = 4;

	typedef enum logic [1:0] {
		REQ_HEADER = 2'd0,
		REQ_BOUND  = 2'd1,
		REQ_INDEX  = 2'd2
	} req_type_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_ADDR
	} state_t;

	typedef enum logic {
		STATUS_OK    = 1'b0,
		STATUS_UNDEF = 1'b1
	} status_code_t;

	// controller to datapath
	typedef struct packed {
		logic wr_hdr;
		logic wr_bnd;
		logic capture;
		logic mac;
		logic set_err;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic id_ok;
		logic bnd_dim_ok;
		logic undef;
		logic beyond;
		logic last;
		logic out_busy;
	} sts_t;

endpackage

// File: rtl/adag_ctrl.sv
`timescale 1ns / 1ps
module adag_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  adag_pkg::sts_t     sts,
	output adag_pkg::cmd_t     cmd
);

	adag_pkg::state_t state_q;
	adag_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= adag_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			adag_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					unique case (req_type)
						adag_pkg::REQ_HEADER: begin
							cmd.wr_hdr = sts.id_ok;
						end
						adag_pkg::REQ_BOUND: begin
							cmd.wr_bnd = sts.id_ok & sts.bnd_dim_ok;
						end
						adag_pkg::REQ_INDEX: begin
							cmd.capture = 1'b1;
							state_d     = adag_pkg::ST_MAC;
						end
						default: begin
						end
					endcase
				end
			end
			adag_pkg::ST_MAC: begin
				if (sts.undef) begin
					cmd.set_err = 1'b1;
					state_d     = adag_pkg::ST_ADDR;
				end else if (sts.beyond) begin
					// drop: dimension past the array's count
					state_d = adag_pkg::ST_IDLE;
				end else begin
					cmd.mac = 1'b1;
					state_d = sts.last ? adag_pkg::ST_ADDR : adag_pkg::ST_IDLE;
				end
			end
			adag_pkg::ST_ADDR: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = adag_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = adag_pkg::ST_IDLE;
			end
		endcase
	end

	a_mac_after_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == adag_pkg::ST_MAC |-> $past(state_q == adag_pkg::ST_IDLE))
		else $error("MAC state entered other than from idle");

	a_addr_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == adag_pkg::ST_ADDR && !sts.out_busy) |=> state_q == adag_pkg::ST_IDLE)
		else $error("address state did not hand off to the output");

endmodule

// File: rtl/adag_dp.sv
`timescale 1ns / 1ps
module adag_dp #(
	parameter int MAX_ARRAYS = adag_pkg::DEF_MAX_ARRAYS,
	parameter int MAX_DIMS   = adag_pkg::DEF_MAX_DIMS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  adag_pkg::cmd_t      cmd,
	output adag_pkg::sts_t      sts,
	input  logic [3:0]          array_id,
	input  logic [30:0]         base_addr,
	input  logic [15:0]         elem_size,
	input  logic [3:0]          dim_count,
	input  logic [3:0]          dim_index,
	input  logic signed [31:0]  lower_bound,
	input  logic signed [31:0]  upper_bound,
	input  logic signed [31:0]  index_value,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  address,
	output logic                status
);

	// ids beyond the 4-bit field can never be addressed
	localparam int NUM_IDS = (MAX_ARRAYS < (1 << adag_pkg::ID_FIELD_W)) ?
		MAX_ARRAYS : (1 << adag_pkg::ID_FIELD_W);
	localparam int ID_W  = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
	localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int SLOTS = NUM_IDS * (1 << DIM_W);

	logic [30:0] base_mem   [NUM_IDS];
	logic [15:0] size_mem   [NUM_IDS];
	logic [31:0] lower_mem  [SLOTS];
	logic [31:0] extent_mem [SLOTS];
	logic [3:0]  dims_q     [NUM_IDS];

	logic [ID_W-1:0]       id_idx;
	logic [ID_W+DIM_W-1:0] slot;
	logic [3:0]            cnt_sat;

	logic [30:0] base_s1;
	logic [15:0] size_s1;
	logic [31:0] lower_s1;
	logic [31:0] extent_s1;
	logic [31:0] idx_s1;
	logic [3:0]  dim_s1;
	logic [3:0]  n_s1;

	logic [31:0] accum_q;
	logic        err_q;
	logic [31:0] term;
	logic [31:0] addr_calc;
	logic        out_valid_q;
	logic [31:0] address_q;
	logic        status_q;

	assign id_idx  = array_id[ID_W-1:0];
	assign slot    = {id_idx, dim_index[DIM_W-1:0]};
	assign cnt_sat = (32'(dim_count) > MAX_DIMS) ? 4'(MAX_DIMS) : dim_count;

	assign sts.id_ok      = 32'(array_id) < NUM_IDS;
	assign sts.bnd_dim_ok = 32'(dim_index) < MAX_DIMS;
	assign sts.undef      = n_s1 == 4'd0;
	assign sts.beyond     = dim_s1 >= n_s1;
	assign sts.last       = ({1'b0, dim_s1} + 5'd1) == {1'b0, n_s1};
	assign sts.out_busy   = out_valid_q & out_stall;

	always_ff @(posedge clk) begin
		if (cmd.wr_hdr) begin
			base_mem[id_idx] <= base_addr;
			size_mem[id_idx] <= elem_size;
		end
		if (cmd.wr_bnd) begin
			lower_mem[slot]  <= lower_bound;
			// hold the extent ready for the fold
			extent_mem[slot] <= 32'(upper_bound - lower_bound + 32'sd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_IDS; i++) begin
				dims_q[i] <= 4'd0;
			end
		end else if (cmd.wr_hdr) begin
			dims_q[id_idx] <= cnt_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			base_s1   <= base_mem[id_idx];
			size_s1   <= size_mem[id_idx];
			lower_s1  <= lower_mem[slot];
			extent_s1 <= extent_mem[slot];
			idx_s1    <= index_value;
			dim_s1    <= dim_index;
			n_s1      <= sts.id_ok ? dims_q[id_idx] : 4'd0;
		end
	end

	assign term      = idx_s1 - lower_s1;
	assign addr_calc = {1'b0, base_s1} + 32'({16'd0, size_s1} * accum_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
			err_q   <= 1'b0;
		end else begin
			if (cmd.mac) begin
				accum_q <= (dim_s1 == 4'd0) ? term : 32'(accum_q * extent_s1) + term;
				err_q   <= 1'b0;
			end else if (cmd.set_err) begin
				accum_q <= '0;
				err_q   <= 1'b1;
			end else if (cmd.emit) begin
				accum_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			address_q <= err_q ? 32'd0 : addr_calc;
			status_q  <= err_q ? adag_pkg::STATUS_UNDEF : adag_pkg::STATUS_OK;
		end
	end

	assign out_valid = out_valid_q;
	assign address   = address_q;
	assign status    = status_q;

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> accum_q == 32'd0)
		else $error("running offset not cleared after a result");

	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == adag_pkg::STATUS_UNDEF) |-> address_q == 32'd0)
		else $error("undefined reference carries a non-zero address");

endmodule

// File: rtl/array_descriptor_address_generator.sv
// Header and bound items are written while idle; the next item is accepted in the following cycle.
// A reference index item is read from the tables, then folded into the offset by multiply-accumulate.
// The last index of a reference then computes the address (element size multiply, base add)
// once the output is free; the result is held in the output register.
// Reset clears the dimension counts (all ids undefined), the running offset and the output valid flag.
// Base, size and bound stores hold no reset value until written.
`timescale 1ns / 1ps
module array_descriptor_address_generator #(
	parameter int MAX_ARRAYS = adag_pkg::DEF_MAX_ARRAYS,
	parameter int MAX_DIMS   = adag_pkg::DEF_MAX_DIMS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic [3:0]         array_id,
	input  logic [30:0]        base_addr,
	input  logic [15:0]        elem_size,
	input  logic [3:0]         dim_count,
	input  logic [3:0]         dim_index,
	input  logic signed [31:0] lower_bound,
	input  logic signed [31:0] upper_bound,
	input  logic signed [31:0] index_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] address,
	output logic               status
);

	adag_pkg::cmd_t cmd;
	adag_pkg::sts_t sts;

	adag_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd)
	);

	adag_dp #(
		.MAX_ARRAYS (MAX_ARRAYS),
		.MAX_DIMS   (MAX_DIMS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.array_id    (array_id),
		.base_addr   (base_addr),
		.elem_size   (elem_size),
		.dim_count   (dim_count),
		.dim_index   (dim_index),
		.lower_bound (lower_bound),
		.upper_bound (upper_bound),
		.index_value (index_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.address     (address),
		.status      (status)
	);

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench;

	localparam int N_ARRAYS = adag_pkg::DEF_MAX_ARRAYS;
	localparam int N_DIMS   = adag_pkg::DEF_MAX_DIMS;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [31:0]            address;
		adag_pkg::status_code_t status;
	} addr_result_t;

	class addr_scoreboard;
		bit [31:0] base_tab[N_ARRAYS];
		bit [15:0] size_tab[N_ARRAYS];
		bit [3:0]  dims_tab[N_ARRAYS];
		bit [31:0] lo_tab[N_ARRAYS * N_DIMS];
		bit [31:0] hi_tab[N_ARRAYS * N_DIMS];
		bit [31:0] offset;
		addr_result_t addr_q[$];
		int errors;

		function new();
			foreach (dims_tab[i]) dims_tab[i] = '0;
			offset = '0;
			errors = 0;
		endfunction

		function int pending();
			return addr_q.size();
		endfunction

		// mirror the descriptor table and queue the address an item gives, if any
		function void note_item(logic [1:0] rt, logic [3:0] id, logic [30:0] base,
				logic [15:0] esize, logic [3:0] cnt, logic [3:0] dim,
				logic [31:0] lo, logic [31:0] hi, logic [31:0] idx);
			int slot;
			bit [31:0] extent, term;
			addr_result_t res;
			slot = int'(id) * N_DIMS + int'(dim);
			case (rt)
				adag_pkg::REQ_HEADER: if (int'(id) < N_ARRAYS) begin
					base_tab[id] = {1'b0, base};
					size_tab[id] = esize;
					dims_tab[id] = (int'(cnt) > N_DIMS) ? 4'(N_DIMS) : cnt;
				end
				adag_pkg::REQ_BOUND: if (int'(id) < N_ARRAYS && int'(dim) < N_DIMS) begin
					lo_tab[slot] = lo;
					hi_tab[slot] = hi;
				end
				adag_pkg::REQ_INDEX: begin
					if (int'(id) >= N_ARRAYS || dims_tab[id] == 0) begin
						offset = '0;
						res.address = '0;
						res.status = adag_pkg::STATUS_UNDEF;
						addr_q = {addr_q, res};
					end else if (dim < dims_tab[id]) begin
						extent = hi_tab[slot] - lo_tab[slot] + 32'd1;
						term = idx - lo_tab[slot];
						offset = (dim == 0) ? term : offset * extent + term;
						if (int'(dim) + 1 == int'(dims_tab[id])) begin
							res.address = base_tab[id] + {16'b0, size_tab[id]} * offset;
							res.status = adag_pkg::STATUS_OK;
							addr_q = {addr_q, res};
							offset = '0;
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic [31:0] addr, logic st);
			addr_result_t want;
			if (addr_q.size() == 0) begin
				$error("unexpected result: address %0d, status %0d", $signed(addr), st);
				errors++;
				return;
			end
			want = addr_q.pop_front();
			if (addr !== want.address) begin
				$error("address: expected %0d, actual %0d", $signed(want.address),
					$signed(addr));
				errors++;
			end
			if (st !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, st);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         req_type = '0;
	logic [3:0]         array_id = '0;
	logic [30:0]        base_addr = '0;
	logic [15:0]        elem_size = '0;
	logic [3:0]         dim_count = '0;
	logic [3:0]         dim_index = '0;
	logic signed [31:0] lower_bound = '0;
	logic signed [31:0] upper_bound = '0;
	logic signed [31:0] index_value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] address;
	logic               status;

	addr_scoreboard sb = new();
	bit bounds_set[N_ARRAYS * N_DIMS];
	int items_sent = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int idle_tab[4] = '{0, 56, 0, 13};
	int stall_tab[4] = '{0, 0, 56, 13};

	array_descriptor_address_generator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.array_id(array_id),
		.base_addr(base_addr),
		.elem_size(elem_size),
		.dim_count(dim_count),
		.dim_index(dim_index),
		.lower_bound(lower_bound),
		.upper_bound(upper_bound),
		.index_value(index_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.address(address),
		.status(status)
	);

	always #10 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(address, status);
	end

	initial begin
		#4_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic send_item(input logic [1:0] rt, input logic [3:0] id,
			input logic [30:0] base, input logic [15:0] esize, input logic [3:0] cnt,
			input logic [3:0] dim, input logic [31:0] lo, input logic [31:0] hi,
			input logic [31:0] idx);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		req_type <= rt;
		array_id <= id;
		base_addr <= base;
		elem_size <= esize;
		dim_count <= cnt;
		dim_index <= dim;
		lower_bound <= lo;
		upper_bound <= hi;
		index_value <= idx;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_item(rt, id, base, esize, cnt, dim, lo, hi, idx);
		if (rt == adag_pkg::REQ_BOUND && int'(dim) < N_DIMS)
			bounds_set[int'(id) * N_DIMS + int'(dim)] = 1'b1;
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_header(input logic [3:0] id, input logic [3:0] cnt,
			input logic [30:0] base, input logic [15:0] esize);
		send_item(adag_pkg::REQ_HEADER, id, base, esize, cnt, 4'($urandom), $urandom,
			$urandom, $urandom);
	endtask

	task automatic send_bound(input logic [3:0] id, input logic [3:0] dim,
			input logic [31:0] lo, input logic [31:0] hi);
		send_item(adag_pkg::REQ_BOUND, id, 31'($urandom), 16'($urandom), 4'($urandom),
			dim, lo, hi, $urandom);
	endtask

	// mostly narrow extents so that in-range subscripts are easy to pick
	function automatic void pick_bounds(output logic [31:0] lo, output logic [31:0] hi);
		if ($urandom_range(9) == 0) begin
			lo = $urandom;
			hi = $urandom;
		end else begin
			lo = 32'($urandom_range(2000)) - 32'd1000;
			hi = lo + 32'($urandom_range(15));
		end
	endfunction

	// never let a reference read bounds that were not written
	task automatic ensure_bounds(input logic [3:0] id, input logic [3:0] dim);
		logic [31:0] lo, hi;
		if (sb.dims_tab[id] != 0 && dim < sb.dims_tab[id]
				&& !bounds_set[int'(id) * N_DIMS + int'(dim)]) begin
			pick_bounds(lo, hi);
			send_bound(id, dim, lo, hi);
		end
	endtask

	task automatic send_index(input logic [3:0] id, input logic [3:0] dim,
			input logic [31:0] idx);
		ensure_bounds(id, dim);
		send_item(adag_pkg::REQ_INDEX, id, 31'($urandom), 16'($urandom), 4'($urandom),
			dim, $urandom, $urandom, idx);
	endtask

	function automatic logic [31:0] pick_index(input logic [3:0] id, input int dim);
		int slot;
		logic [31:0] span;
		slot = int'(id) * N_DIMS + dim;
		span = sb.hi_tab[slot] - sb.lo_tab[slot];
		if ($urandom_range(9) != 0 && span < 32'd1000)
			return sb.lo_tab[slot] + 32'($urandom_range(int'(span)));
		return $urandom;
	endfunction

	task automatic send_reference(input logic [3:0] id, input int first, input int stop);
		for (int d = first; d < stop; d++) begin
			ensure_bounds(id, 4'(d));
			send_index(id, 4'(d), pick_index(id, d));
		end
	endtask

	task automatic define_array(input logic [3:0] id);
		int cnt;
		logic [31:0] lo, hi;
		cnt = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(1, 4);
		send_header(id, 4'(cnt), 31'($urandom), 16'($urandom_range(1, 65535)));
		for (int d = 0; d < cnt && d < N_DIMS; d++) begin
			pick_bounds(lo, hi);
			send_bound(id, 4'(d), lo, hi);
		end
	endtask

	function automatic int find_defined();
		int start;
		start = $urandom_range(N_ARRAYS - 1);
		for (int k = 0; k < N_ARRAYS; k++)
			if (sb.dims_tab[(start + k) % N_ARRAYS] != 0)
				return (start + k) % N_ARRAYS;
		return -1;
	endfunction

	task automatic random_step();
		int pick, id, n, first;
		logic [31:0] lo, hi;
		pick = $urandom_range(99);
		id = find_defined();
		if (id < 0 || (pick >= 60 && pick < 72)) begin
			define_array(4'($urandom));
		end else if (pick < 60) begin
			send_reference(4'(id), 0, int'(sb.dims_tab[id]));
		end else if (pick < 76) begin
			send_header(4'($urandom), 4'($urandom), 31'($urandom), 16'($urandom));
		end else if (pick < 84) begin
			// broken reference: may start late or stop early
			n = int'(sb.dims_tab[id]);
			first = $urandom_range(n - 1);
			send_reference(4'(id), first, $urandom_range(first, n));
		end else if (pick < 90) begin
			send_index(4'($urandom), 4'($urandom), $urandom);
		end else if (pick < 94) begin
			pick_bounds(lo, hi);
			send_bound(4'($urandom), 4'($urandom), lo, hi);
		end else begin
			send_item(REQ_UNUSED, 4'($urandom), 31'($urandom), 16'($urandom), 4'($urandom),
				4'($urandom), $urandom, $urandom, $urandom);
		end
	endtask

	// hold the sender off until every queued address has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0) @(negedge clk);
	endtask

	initial begin
		int goal;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// reference before anything is defined, then an unused request type
		send_index(4'd0, 4'd0, 32'h7FFF_FFFF);
		send_item(REQ_UNUSED, 4'hF, '1, '1, '1, '1, '1, '1, '1);

		// widest base, size and bounds; the address wraps
		send_header(4'd15, 4'd1, 31'h7FFF_FFFF, 16'hFFFF);
		send_bound(4'd15, 4'd0, 32'h8000_0000, 32'h7FFF_FFFF);
		send_index(4'd15, 4'd0, 32'h7FFF_FFFF);
		send_index(4'd15, 4'd1, 32'h8000_0000);

		send_header(4'd0, 4'd2, 31'd0, 16'd1);
		send_bound(4'd0, 4'd0, -32'sd5, 32'sd5);
		send_bound(4'd0, 4'd1, 32'sd0, 32'sd3);
		send_bound(4'd0, 4'd12, 32'sd0, 32'sd0);
		send_index(4'd0, 4'd0, 32'd2);
		send_index(4'd0, 4'd1, 32'd1);
		send_index(4'd0, 4'd1, 32'd3);

		// dimension count saturates at the table depth
		send_header(4'd1, 4'd15, 31'($urandom), 16'($urandom_range(1, 65535)));
		send_index(4'd1, 4'd9, $urandom);
		send_index(4'd1, 4'd10, $urandom);

		// zero count undefines; redefinition keeps the bounds
		send_header(4'd0, 4'd0, 31'd0, 16'd1);
		send_index(4'd0, 4'd0, 32'd0);
		send_header(4'd0, 4'd2, 31'h1234_5678, 16'd8);
		send_index(4'd0, 4'd0, -32'sd5);
		send_index(4'd3, 4'd0, 32'd0);
		send_index(4'd0, 4'd1, 32'd2);
		wait_drained();

		for (int p = 0; p < 4; p++) begin
			idle_pct = idle_tab[p];
			stall_pct = stall_tab[p];
			goal = items_sent + 150;
			while (items_sent < goal) random_step();
			wait_drained();
		end

		stall_pct = 0;
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
